>>> hdl/rmth_pkg.sv
`default_nettype none
package rmth_pkg;

  localparam int HEAP_DEPTH = 1024;
  localparam int DATA_WIDTH = 32;

  localparam int IDX_W  = $clog2(HEAP_DEPTH);
  localparam int CNT_W  = IDX_W + 1;
  localparam int TOT_W  = CNT_W + 1;
  localparam int ADDR_W = IDX_W + 1;
  localparam int SMP_W  = 32;
  localparam int MED_W  = 32;
  localparam int SCNT_W = 12;
  localparam int OUT_TDATA_W = 48;

  // heap select: lower half is a max-heap, upper half a min-heap
  localparam logic HEAP_LO = 1'b0;
  localparam logic HEAP_HI = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_OVF,
    OP_SD_FULL,
    OP_PUSH_KEY_LO,
    OP_PUSH_KEY_HI,
    OP_PUSH_AUX,
    OP_POP_A,
    OP_POP_B,
    OP_POP_C,
    OP_PU_TEST,
    OP_PU_CMP,
    OP_SD_L,
    OP_SD_R,
    OP_SD_CMP,
    OP_MED_RD
  } op_e;

  typedef struct packed {
    logic full;
    logic to_lower;
    logic lo_full;
    logic bal_lo;
    logic bal_hi;
    logic pu_done;
    logic pu_up;
    logic sd_leaf;
    logic sd_stop;
  } dp_status_t;

  typedef struct packed {
    op_e  op;
    logic out_load;
  } dp_cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SD_L,
    ST_SD_R,
    ST_SD_CMP,
    ST_PU_TEST,
    ST_PU_CMP,
    ST_FULL_PUSH,
    ST_BAL,
    ST_POP_B,
    ST_POP_C,
    ST_POP_PUSH,
    ST_MED,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    RET_FULL,
    RET_BAL,
    RET_POP,
    RET_MED
  } ret_e;

  // true when a sits nearer the root than b in the given heap
  function automatic logic outranks(input logic [DATA_WIDTH-1:0] a,
                                    input logic [DATA_WIDTH-1:0] b,
                                    input logic heap);
    logic res;
    if (heap == HEAP_LO) begin
      res = $signed(a) > $signed(b);
    end else begin
      res = $signed(a) < $signed(b);
    end
    return res;
  endfunction

endpackage
`default_nettype wire

>>> hdl/running_median_two_heaps_core.sv
// Running median over a stream of signed samples, kept in two binary heaps
// (max-heap for the lower half, min-heap for the upper half) in one RAM.
//
// Input channel s_axis: tdata = sample, tuser = restart (empties both heaps
// before the sample goes in). Output channel m_axis: one item per input
// item, tdata = {sample_count, median}, tuser = overflow (sample dropped
// because both heaps were full; median and count still reported).
//
// Items are handled one at a time, one RAM read or write per cycle. Each
// item is pushed into one heap and climbs toward the root; when it belongs
// in a full lower heap, it takes that heap's root place and sifts down, and
// the old root is pushed into the upper heap. A rebalance, where needed, then
// pops the root of the larger heap, sifts its last entry down from the root
// and pushes the popped value into the other heap. A dropped sample goes
// straight to the median read. The next item can be taken in the cycle after
// the result is loaded.
// The result sits in an output register; the block takes the next item
// while it waits, and stalls before loading a new result until the old one
// is taken. Reset clears the heap sizes and the handshake state only; the
// RAM needs no clearing since only entries below the sizes are ever used.
`default_nettype none
module running_median_two_heaps_core (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [31:0] s_axis_tdata_i,   // [31:0] sample
  input  wire         s_axis_tuser_i,   // [0] restart
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // [31:0] median, [43:32] sample_count, pad
  output logic        m_axis_tuser_o    // [0] overflow
);
  import rmth_pkg::*;

  dp_cmd_t          cmd;
  dp_status_t       status;
  logic [MED_W-1:0]  median;
  logic [SCNT_W-1:0] count;

  rmth_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  rmth_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sample_i   (s_axis_tdata_i),
    .restart_i  (s_axis_tuser_i),
    .status_o   (status),
    .median_o   (median),
    .count_o    (count),
    .overflow_o (m_axis_tuser_o)
  );

  // fields packed from bit 0 up, zero fill to whole bytes
  assign m_axis_tdata_o = {(OUT_TDATA_W - MED_W - SCNT_W)'(0), count, median};

endmodule
`default_nettype wire

>>> hdl/rmth_dp.sv
`default_nettype none
module rmth_dp (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  rmth_pkg::dp_cmd_t            cmd_i,
  input  wire  [rmth_pkg::SMP_W-1:0]   sample_i,
  input  wire                          restart_i,
  output rmth_pkg::dp_status_t         status_o,
  output logic [rmth_pkg::MED_W-1:0]   median_o,
  output logic [rmth_pkg::SCNT_W-1:0]  count_o,
  output logic                         overflow_o
);
  import rmth_pkg::*;

  logic [DATA_WIDTH-1:0] mem_q [2*HEAP_DEPTH];
  logic [DATA_WIDTH-1:0] rd_q;

  logic [DATA_WIDTH-1:0] key_q, key_d, mov_q, mov_d, aux_q, aux_d, ch_q, ch_d;
  logic [IDX_W-1:0]      idx_q, idx_d;
  logic [CNT_W-1:0]      n_q, n_d, lo_q, lo_d, hi_q, hi_d;
  logic                  heap_q, heap_d, ovf_q, ovf_d;
  logic [MED_W-1:0]      med_q;
  logic [SCNT_W-1:0]     cnt_q;
  logic                  ovo_q;

  logic                  we, re;
  logic [ADDR_W-1:0]     waddr, raddr;
  logic [DATA_WIDTH-1:0] wdata;

  logic [CNT_W-1:0]      cur_cnt;
  logic [TOT_W-1:0]      total;
  logic [IDX_W-1:0]      parent;
  logic [IDX_W+1:0]      l_w, r_w;
  logic                  has_l, has_r;
  logic [DATA_WIDTH-1:0] best_v;
  logic [IDX_W-1:0]      best_i;
  logic                  moved;
  logic                  med_heap;

  assign cur_cnt = (heap_q == HEAP_LO) ? lo_q : hi_q;
  assign total   = TOT_W'(lo_q) + TOT_W'(hi_q);
  assign parent  = (idx_q - IDX_W'(1)) >> 1;
  assign l_w     = {1'b0, idx_q, 1'b1};
  assign r_w     = l_w + (IDX_W+2)'(1);
  assign has_l   = l_w < (IDX_W+2)'(n_q);
  assign has_r   = r_w < (IDX_W+2)'(n_q);
  assign med_heap = (lo_q >= hi_q) ? HEAP_LO : HEAP_HI;

  // best of hole value and its children for the sift-down step
  always_comb begin
    best_v = mov_q;
    best_i = idx_q;
    moved  = 1'b0;
    if (outranks(ch_q, mov_q, heap_q)) begin
      best_v = ch_q;
      best_i = l_w[IDX_W-1:0];
      moved  = 1'b1;
    end
    if (has_r && outranks(rd_q, best_v, heap_q)) begin
      best_v = rd_q;
      best_i = r_w[IDX_W-1:0];
      moved  = 1'b1;
    end
  end

  always_comb begin
    status_o.full     = total >= TOT_W'(2*HEAP_DEPTH);
    status_o.to_lower = (lo_q == '0) || ($signed(key_q) <= $signed(rd_q));
    status_o.lo_full  = lo_q >= CNT_W'(HEAP_DEPTH);
    status_o.bal_lo   = lo_q > (hi_q + CNT_W'(1));
    status_o.bal_hi   = hi_q > lo_q;
    status_o.pu_done  = idx_q == '0;
    status_o.pu_up    = outranks(mov_q, rd_q, heap_q);
    status_o.sd_leaf  = !has_l;
    status_o.sd_stop  = !moved;
  end

  always_comb begin
    key_d = key_q; mov_d = mov_q; aux_d = aux_q; ch_d = ch_q;
    idx_d = idx_q; n_d = n_q; lo_d = lo_q; hi_d = hi_q;
    heap_d = heap_q; ovf_d = ovf_q;
    we = 1'b0; re = 1'b0;
    waddr = {heap_q, idx_q};
    wdata = mov_q;
    raddr = {heap_q, IDX_W'(0)};
    case (cmd_i.op)
      OP_LOAD: begin
        key_d  = sample_i[DATA_WIDTH-1:0];
        heap_d = HEAP_LO;
        ovf_d  = 1'b0;
        if (restart_i) begin
          lo_d = '0;
          hi_d = '0;
        end
        re    = 1'b1;
        raddr = {HEAP_LO, IDX_W'(0)};
      end
      OP_OVF: ovf_d = 1'b1;
      OP_SD_FULL: begin
        mov_d  = key_q;
        aux_d  = rd_q;
        heap_d = HEAP_LO;
        n_d    = lo_q;
        idx_d  = '0;
      end
      OP_PUSH_KEY_LO: begin
        mov_d  = key_q;
        heap_d = HEAP_LO;
        idx_d  = lo_q[IDX_W-1:0];
        lo_d   = lo_q + CNT_W'(1);
      end
      OP_PUSH_KEY_HI: begin
        mov_d  = key_q;
        heap_d = HEAP_HI;
        idx_d  = hi_q[IDX_W-1:0];
        hi_d   = hi_q + CNT_W'(1);
      end
      OP_PUSH_AUX: begin
        mov_d  = aux_q;
        heap_d = ~heap_q;
        if (heap_q == HEAP_LO) begin
          idx_d = hi_q[IDX_W-1:0];
          hi_d  = hi_q + CNT_W'(1);
        end else begin
          idx_d = lo_q[IDX_W-1:0];
          lo_d  = lo_q + CNT_W'(1);
        end
      end
      OP_POP_A: begin
        heap_d = status_o.bal_lo ? HEAP_LO : HEAP_HI;
        re     = 1'b1;
        raddr  = {heap_d, IDX_W'(0)};
      end
      OP_POP_B: begin
        aux_d = rd_q;
        re    = 1'b1;
        raddr = {heap_q, IDX_W'(cur_cnt - CNT_W'(1))};
        if (heap_q == HEAP_LO) lo_d = lo_q - CNT_W'(1);
        else                   hi_d = hi_q - CNT_W'(1);
      end
      OP_POP_C: begin
        mov_d = rd_q;
        n_d   = cur_cnt;
        idx_d = '0;
      end
      OP_PU_TEST: begin
        if (idx_q == '0) begin
          we = 1'b1;
        end else begin
          re    = 1'b1;
          raddr = {heap_q, parent};
        end
      end
      OP_PU_CMP: begin
        we = 1'b1;
        if (status_o.pu_up) begin
          wdata = rd_q;
          idx_d = parent;
        end
      end
      OP_SD_L: begin
        if (!has_l) begin
          we = 1'b1;
        end else begin
          re    = 1'b1;
          raddr = {heap_q, l_w[IDX_W-1:0]};
        end
      end
      OP_SD_R: begin
        ch_d = rd_q;
        if (has_r) begin
          re    = 1'b1;
          raddr = {heap_q, r_w[IDX_W-1:0]};
        end
      end
      OP_SD_CMP: begin
        we    = 1'b1;
        wdata = best_v;
        idx_d = best_i;
      end
      OP_MED_RD: begin
        re    = 1'b1;
        raddr = {med_heap, IDX_W'(0)};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    if (re) rd_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q <= '0;
      hi_q <= '0;
    end else begin
      lo_q <= lo_d;
      hi_q <= hi_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    mov_q  <= mov_d;
    aux_q  <= aux_d;
    ch_q   <= ch_d;
    idx_q  <= idx_d;
    n_q    <= n_d;
    heap_q <= heap_d;
    ovf_q  <= ovf_d;
    if (cmd_i.out_load) begin
      // both heaps empty cannot follow an accepted item, kept for safety
      med_q <= (lo_q == '0 && hi_q == '0) ? '0 : MED_W'($signed(rd_q));
      cnt_q <= SCNT_W'(total);
      ovo_q <= ovf_q;
    end
  end

  assign median_o   = med_q;
  assign count_o    = cnt_q;
  assign overflow_o = ovo_q;

endmodule
`default_nettype wire

>>> hdl/rmth_ctrl.sv
`default_nettype none
module rmth_ctrl (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  input  rmth_pkg::dp_status_t  status_i,
  output rmth_pkg::dp_cmd_t     cmd_o
);
  import rmth_pkg::*;

  state_e state_q, state_d;
  ret_e   ret_q, ret_d;
  logic   ov_q, ov_d;
  state_e ret_state;

  always_comb begin
    case (ret_q)
      RET_FULL: ret_state = ST_FULL_PUSH;
      RET_BAL:  ret_state = ST_BAL;
      RET_POP:  ret_state = ST_POP_PUSH;
      RET_MED:  ret_state = ST_MED;
      default:  ret_state = ST_MED;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ret_q   <= RET_BAL;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      ov_q    <= ov_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    ov_d    = ov_q && !out_ready_i;
    cmd_o.op       = OP_NONE;
    cmd_o.out_load = 1'b0;
    in_ready_o     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (status_i.full) begin
          cmd_o.op = OP_OVF;
          state_d  = ST_MED;
        end else if (status_i.to_lower && status_i.lo_full) begin
          cmd_o.op = OP_SD_FULL;
          ret_d    = RET_FULL;
          state_d  = ST_SD_L;
        end else begin
          cmd_o.op = status_i.to_lower ? OP_PUSH_KEY_LO : OP_PUSH_KEY_HI;
          ret_d    = RET_BAL;
          state_d  = ST_PU_TEST;
        end
      end
      ST_SD_L: begin
        cmd_o.op = OP_SD_L;
        state_d  = status_i.sd_leaf ? ret_state : ST_SD_R;
      end
      ST_SD_R: begin
        cmd_o.op = OP_SD_R;
        state_d  = ST_SD_CMP;
      end
      ST_SD_CMP: begin
        cmd_o.op = OP_SD_CMP;
        state_d  = status_i.sd_stop ? ret_state : ST_SD_L;
      end
      ST_PU_TEST: begin
        cmd_o.op = OP_PU_TEST;
        state_d  = status_i.pu_done ? ret_state : ST_PU_CMP;
      end
      ST_PU_CMP: begin
        cmd_o.op = OP_PU_CMP;
        state_d  = status_i.pu_up ? ST_PU_TEST : ret_state;
      end
      ST_FULL_PUSH: begin
        cmd_o.op = OP_PUSH_AUX;
        ret_d    = RET_BAL;
        state_d  = ST_PU_TEST;
      end
      ST_BAL: begin
        if (status_i.bal_lo || status_i.bal_hi) begin
          cmd_o.op = OP_POP_A;
          state_d  = ST_POP_B;
        end else begin
          state_d  = ST_MED;
        end
      end
      ST_POP_B: begin
        cmd_o.op = OP_POP_B;
        state_d  = ST_POP_C;
      end
      ST_POP_C: begin
        cmd_o.op = OP_POP_C;
        ret_d    = RET_POP;
        state_d  = ST_SD_L;
      end
      ST_POP_PUSH: begin
        cmd_o.op = OP_PUSH_AUX;
        ret_d    = RET_MED;
        state_d  = ST_PU_TEST;
      end
      ST_MED: begin
        cmd_o.op = OP_MED_RD;
        state_d  = ST_OUT;
      end
      ST_OUT: begin
        if (!ov_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          ov_d           = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = ov_q;

endmodule
`default_nettype wire
